// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue core.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int CAPACITY   = 16;
   localparam int WORD_BITS  = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      KIND_PUSH_FRONT = 2'd0,
      KIND_PUSH_BACK  = 2'd1,
      KIND_POP_FRONT  = 2'd2,
      KIND_POP_BACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_OVERFLOW  = 2'd1,
      FAULT_UNDERFLOW = 2'd2
   } fault_type;

   // Qualified shift/write commands broadcast to every cell
   typedef struct packed {
      logic     push_front;
      logic     push_back;
      logic     pop_front;
      word_type data_word;
   } dq_ctl_type;

endpackage

// ===== rtl/dq_req_if.sv =====
// ----------------------------------------------------------------------------
// dq_req_if
// Operation channel: valid/ready handshake with kind and data word.
// ----------------------------------------------------------------------------
interface dq_req_if;
   logic             valid;
   logic             ready;
   dq_pkg::kind_type kind;
   dq_pkg::word_type data_word;

   modport source (output valid, output kind, output data_word, input ready);
   modport sink   (input valid, input kind, input data_word, output ready);
endinterface

// ===== rtl/dq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dq_rsp_if
// Status channel: valid/ready handshake with the queue status after an operation.
// ----------------------------------------------------------------------------
interface dq_rsp_if;
   logic              valid;
   logic              ready;
   dq_pkg::word_type  front_word;
   dq_pkg::word_type  back_word;
   logic              words_valid;
   dq_pkg::count_type entry_count;
   logic              is_full;
   dq_pkg::fault_type fault;

   modport source (output valid, output front_word, output back_word, output words_valid,
                   output entry_count, output is_full, output fault, input ready);
   modport sink   (input valid, input front_word, input back_word, input words_valid,
                   input entry_count, input is_full, input fault, output ready);
endinterface

// ===== rtl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded deque of data words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Cell 0 always holds the front word; a push at the front shifts every cell
// one place toward the back, a pop at the front shifts them toward the front,
// and back operations only write the cell past the tail or move the count.
// One operation is accepted per clock cycle; the cells and the pending flag
// update at the accepting edge, and the output register then samples them
// to present the status transaction. A push
// into a full queue is dropped with an overflow fault, a pop from an empty
// queue is ignored with an underflow fault. Throughput drops only while the
// status output is stalled.
module double_ended_queue_core (
   input  logic      clock,
   input  logic      reset,
   dq_req_if.sink    req_chan,
   dq_rsp_if.source  rsp_chan
);

   dq_pkg::word_type   cell_word [dq_pkg::CAPACITY];
   dq_pkg::dq_ctl_type ctl;

   dq_pkg::count_type  count_ff, count_in;
   logic               pend_ff, pend_in;
   dq_pkg::fault_type  fault_ff, fault_in;

   logic               rsp_valid_ff, rsp_valid_in;
   dq_pkg::word_type   rsp_front_ff, rsp_back_ff;
   logic               rsp_words_valid_ff;
   dq_pkg::count_type  rsp_count_ff;
   logic               rsp_full_ff;
   dq_pkg::fault_type  rsp_fault_ff;

   logic               accept;
   logic               pend_move;
   logic               is_full;
   logic               is_empty;
   dq_pkg::word_type   back_word;

   assign is_full   = (count_ff == dq_pkg::COUNT_BITS'(dq_pkg::CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign pend_move = pend_ff && (!rsp_valid_ff || rsp_chan.ready);

   assign req_chan.ready = !pend_ff || pend_move;
   assign accept         = req_chan.valid && req_chan.ready;

   // Decode the operation and qualify it against full/empty
   always_comb begin
      ctl            = '0;
      ctl.data_word  = req_chan.data_word;
      count_in       = count_ff;
      fault_in       = fault_ff;
      pend_in        = pend_ff && !pend_move;
      if (accept) begin
         pend_in  = 1'b1;
         fault_in = dq_pkg::FAULT_NONE;
         unique case (req_chan.kind) inside
            dq_pkg::KIND_PUSH_FRONT,
            dq_pkg::KIND_PUSH_BACK: begin
               if (is_full) begin
                  fault_in = dq_pkg::FAULT_OVERFLOW;
               end else begin
                  ctl.push_front = (req_chan.kind == dq_pkg::KIND_PUSH_FRONT);
                  ctl.push_back  = (req_chan.kind == dq_pkg::KIND_PUSH_BACK);
                  count_in       = count_ff + dq_pkg::COUNT_BITS'(1);
               end
            end
            dq_pkg::KIND_POP_FRONT,
            dq_pkg::KIND_POP_BACK: begin
               if (is_empty) begin
                  fault_in = dq_pkg::FAULT_UNDERFLOW;
               end else begin
                  ctl.pop_front = (req_chan.kind == dq_pkg::KIND_POP_FRONT);
                  count_in      = count_ff - dq_pkg::COUNT_BITS'(1);
               end
            end
            default: begin
               fault_in = dq_pkg::FAULT_NONE;
            end
         endcase
      end
   end

   for (genvar i = 0; i < dq_pkg::CAPACITY; i++) begin : g_cell
      dq_pkg::word_type prev_word;
      dq_pkg::word_type next_word;
      logic             tail_slot;

      if (i == 0) begin : g_first
         assign prev_word = req_chan.data_word;
      end else begin : g_mid_prev
         assign prev_word = cell_word[i-1];
      end

      if (i == dq_pkg::CAPACITY - 1) begin : g_last
         assign next_word = cell_word[i];
      end else begin : g_mid_next
         assign next_word = cell_word[i+1];
      end

      assign tail_slot = (count_ff == dq_pkg::COUNT_BITS'(i));

      dq_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .prev_word (prev_word),
         .next_word (next_word),
         .tail_slot (tail_slot),
         .cell_word (cell_word[i])
      );
   end

   // Pick the tail cell; zero when empty
   always_comb begin
      back_word = '0;
      for (int i = 0; i < dq_pkg::CAPACITY; i++) begin
         if (count_ff == dq_pkg::COUNT_BITS'(i + 1)) begin
            back_word = back_word | cell_word[i];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         fault_ff     <= dq_pkg::FAULT_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture status from the settled cells
   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_front_ff       <= is_empty ? '0 : cell_word[0];
         rsp_back_ff        <= back_word;
         rsp_words_valid_ff <= !is_empty;
         rsp_count_ff       <= count_ff;
         rsp_full_ff        <= is_full;
         rsp_fault_ff       <= fault_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.front_word  = rsp_front_ff;
   assign rsp_chan.back_word   = rsp_back_ff;
   assign rsp_chan.words_valid = rsp_words_valid_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.is_full     = rsp_full_ff;
   assign rsp_chan.fault       = rsp_fault_ff;

endmodule

// ===== rtl/dq_cell.sv =====
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the shifting queue; takes a word from either neighbor or the input.
// ----------------------------------------------------------------------------
module dq_cell (
   input  logic               clock,
   input  dq_pkg::dq_ctl_type ctl,
   input  dq_pkg::word_type   prev_word,
   input  dq_pkg::word_type   next_word,
   input  logic               tail_slot,
   output dq_pkg::word_type   cell_word
);

   dq_pkg::word_type word_ff;
   dq_pkg::word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.push_front) begin
         // shift toward the back
         word_in = prev_word;
      end else if (ctl.push_back && tail_slot) begin
         word_in = ctl.data_word;
      end else if (ctl.pop_front) begin
         // shift toward the front
         word_in = next_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign cell_word = word_ff;

endmodule

// ===== bench/double_ended_queue_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// double_ended_queue_core_tb
// Self-checking bench for the deque core. Operations are driven over the
// request channel and every status transaction is compared, field by field,
// with a ring-store model of the queue kept in the bench.
// ----------------------------------------------------------------------------
module double_ended_queue_core_tb;

   typedef struct {
      dq_pkg::word_type  front_word;
      dq_pkg::word_type  back_word;
      logic              words_valid;
      dq_pkg::count_type entry_count;
      logic              is_full;
      dq_pkg::fault_type fault;
   } deque_status_type;

   logic clock = 1'b0;
   logic reset;

   dq_req_if req_bus ();
   dq_rsp_if rsp_bus ();

   double_ended_queue_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Bench copy of the queue
   dq_pkg::word_type  ring_words [dq_pkg::CAPACITY];
   int unsigned       head_idx;
   int unsigned       fill_level;
   deque_status_type  pending_status [$];
   deque_status_type  want_status;
   int                fail_count;
   bit                calm_mode;

   function automatic deque_status_type apply_deque_op(dq_pkg::kind_type k,
                                                       dq_pkg::word_type w);
      deque_status_type s;
      s.fault = dq_pkg::FAULT_NONE;
      if (k == dq_pkg::KIND_PUSH_FRONT || k == dq_pkg::KIND_PUSH_BACK) begin
         if (fill_level == dq_pkg::CAPACITY) begin
            s.fault = dq_pkg::FAULT_OVERFLOW;
         end else if (k == dq_pkg::KIND_PUSH_FRONT) begin
            head_idx = (head_idx == 0) ? dq_pkg::CAPACITY - 1 : head_idx - 1;
            ring_words[head_idx] = w;
            fill_level++;
         end else begin
            ring_words[(head_idx + fill_level) % dq_pkg::CAPACITY] = w;
            fill_level++;
         end
      end else begin
         if (fill_level == 0) begin
            s.fault = dq_pkg::FAULT_UNDERFLOW;
         end else begin
            if (k == dq_pkg::KIND_POP_FRONT) head_idx = (head_idx + 1) % dq_pkg::CAPACITY;
            fill_level--;
         end
      end
      s.words_valid = (fill_level != 0);
      s.entry_count = dq_pkg::count_type'(fill_level);
      s.is_full     = (fill_level == dq_pkg::CAPACITY);
      s.front_word  = '0;
      s.back_word   = '0;
      if (fill_level != 0) begin
         s.front_word = ring_words[head_idx];
         s.back_word  = ring_words[(head_idx + fill_level - 1) % dq_pkg::CAPACITY];
      end
      return s;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] want, logic [63:0] got);
      $display("MISMATCH at %0t: %s expected %0h got %0h", $time, field, want, got);
      fail_count++;
   endtask

   function automatic dq_pkg::word_type random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return dq_pkg::word_type'($urandom);
      endcase
   endfunction

   // Issue one operation; predict its status at the accepting edge
   task automatic send_op(dq_pkg::kind_type k, dq_pkg::word_type w);
      while (!calm_mode && $urandom_range(99) < 37) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= k;
      req_bus.data_word <= w;
      do @(posedge clock); while (!req_bus.ready);
      pending_status.push_back(apply_deque_op(k, w));
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= calm_mode ? 1'b1 : ($urandom_range(99) >= 37);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_status.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(0), 64'(1));
         end else begin
            want_status = pending_status.pop_front();
            if (rsp_bus.front_word !== want_status.front_word)
               report_mismatch("front_word", 64'(want_status.front_word),
                               64'(rsp_bus.front_word));
            if (rsp_bus.back_word !== want_status.back_word)
               report_mismatch("back_word", 64'(want_status.back_word),
                               64'(rsp_bus.back_word));
            if (rsp_bus.words_valid !== want_status.words_valid)
               report_mismatch("words_valid", 64'(want_status.words_valid),
                               64'(rsp_bus.words_valid));
            if (rsp_bus.entry_count !== want_status.entry_count)
               report_mismatch("entry_count", 64'(want_status.entry_count),
                               64'(rsp_bus.entry_count));
            if (rsp_bus.is_full !== want_status.is_full)
               report_mismatch("is_full", 64'(want_status.is_full), 64'(rsp_bus.is_full));
            if (rsp_bus.fault !== want_status.fault)
               report_mismatch("fault", 64'(want_status.fault), 64'(rsp_bus.fault));
         end
      end
   end

   // Pops on the empty queue right after reset
   task automatic test_empty_pops();
      send_op(dq_pkg::KIND_POP_FRONT, '1);
      send_op(dq_pkg::KIND_POP_BACK, 32'h5555_5555);
   endtask

   // Fill from both ends with extreme words, wrap the front index, overflow, then pop both ends
   task automatic test_fill_and_overflow();
      send_op(dq_pkg::KIND_PUSH_FRONT, '1);
      send_op(dq_pkg::KIND_PUSH_BACK, '0);
      for (int i = 0; i < dq_pkg::CAPACITY - 2; i++) begin
         send_op(i[0] ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT,
                 i[1] ? 32'hAAAA_AAAA : 32'h5555_5555);
      end
      send_op(dq_pkg::KIND_PUSH_FRONT, 32'h1234_5678);
      send_op(dq_pkg::KIND_PUSH_BACK, 32'h8765_4321);
      send_op(dq_pkg::KIND_POP_FRONT, '0);
      send_op(dq_pkg::KIND_POP_BACK, '0);
   endtask

   // Hold the sender until every status transaction has come back
   task automatic test_drain_pause();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_status.size() == 0);
      send_op(dq_pkg::KIND_PUSH_BACK, random_word());
      send_op(dq_pkg::KIND_POP_FRONT, random_word());
   endtask

   // Segments biased toward filling, draining or neither, so the count swings
   task automatic test_random_mix(int items);
      int push_pct;
      dq_pkg::kind_type k;
      push_pct = 50;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(2))
               0: push_pct = 80;
               1: push_pct = 20;
               default: push_pct = 50;
            endcase
         end
         if ($urandom_range(99) < push_pct)
            k = $urandom_range(1) ? dq_pkg::KIND_PUSH_BACK : dq_pkg::KIND_PUSH_FRONT;
         else
            k = $urandom_range(1) ? dq_pkg::KIND_POP_BACK : dq_pkg::KIND_POP_FRONT;
         send_op(k, random_word());
      end
   endtask

   // Stretch with no idling on either side
   task automatic test_back_to_back(int items);
      calm_mode = 1'b1;
      test_random_mix(items);
      calm_mode = 1'b0;
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.kind      = dq_pkg::KIND_PUSH_FRONT;
      req_bus.data_word = '0;
      rsp_bus.ready     = 1'b0;
      head_idx          = 0;
      fill_level        = 0;
      fail_count        = 0;
      calm_mode         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_pops();
      test_fill_and_overflow();
      test_random_mix(600);
      test_drain_pause();
      test_back_to_back(300);
      test_random_mix(550);

      @(negedge clock);
      req_bus.valid <= 1'b0;
      wait (pending_status.size() == 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/dq_pkg.sv
rtl/dq_req_if.sv
rtl/dq_rsp_if.sv
rtl/dq_cell.sv
rtl/double_ended_queue_core.sv
bench/double_ended_queue_core_tb.sv
